// ----- sv/assert_macros.svh -----
// Assertion macros for the rational arithmetic unit checker.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked check, off while in reset
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// clocked check, also active during reset
`define RAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);
`endif

// ----- sv/rau_pkg.sv -----
// Shared widths, codes and types of the rational arithmetic unit.
// No dependencies.
package rau_pkg;

  localparam int NUM_W     = 32;
  localparam int DEN_W     = 31;
  localparam int MAG_W     = 32;
  localparam int NW        = 63;
  localparam int DW        = 62;
  localparam int KW        = 6;
  localparam int GCD_STEPS = NW + DW;
  localparam int RAU_WIDTH = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef struct packed {
    logic neg;
    logic err;
    logic zero;
  } side_t;

endpackage

// ----- sv/rau_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on rau_pkg.
interface rau_req_if import rau_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [NUM_W-1:0] left_num;
  logic [DEN_W-1:0]        left_den;
  logic signed [NUM_W-1:0] right_num;
  logic [DEN_W-1:0]        right_den;

  modport source (output valid, req_type, left_num, left_den, right_num, right_den,
                  input ready);
  modport sink (input valid, req_type, left_num, left_den, right_num, right_den,
                output ready);
endinterface

interface rau_rsp_if import rau_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] result_num;
  logic [DEN_W-1:0]        result_den;
  status_t                 status;

  modport source (output valid, result_num, result_den, status, input ready);
  modport sink (input valid, result_num, result_den, status, output ready);
endinterface

// ----- sv/rau_reduce.sv -----
// Pipelined binary gcd followed by two pipelined restoring dividers.
// Reduces mag/den by their gcd; depends on rau_pkg.
module rau_reduce import rau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_mag,
  input  logic [DW-1:0] in_den,
  input  side_t         in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_mag,
  output logic [DW-1:0] out_den,
  output side_t         out_side
);

  typedef struct packed {
    logic [NW-1:0] u;
    logic [DW-1:0] v;
    logic [KW-1:0] k;
  } gst_t;

  function automatic gst_t gcd_step(gst_t st);
    gst_t nx;
    nx = st;
    if (st.u == '0) begin
      nx = st;
    end else if (!st.u[0] && !st.v[0]) begin
      nx.u = st.u >> 1;
      nx.v = st.v >> 1;
      nx.k = st.k + 1'b1;
    end else if (!st.u[0]) begin
      nx.u = st.u >> 1;
    end else if (!st.v[0]) begin
      nx.v = st.v >> 1;
    end else if (st.u >= NW'(st.v)) begin
      nx.u = (st.u - NW'(st.v)) >> 1;
    end else begin
      nx.v = (st.v - DW'(st.u)) >> 1;
    end
    return nx;
  endfunction

  gst_t          g_r    [0:GCD_STEPS];
  logic [NW-1:0] gm_r   [0:GCD_STEPS];
  logic [DW-1:0] gd_r   [0:GCD_STEPS];
  side_t         gs_r   [0:GCD_STEPS];
  logic [GCD_STEPS:0] gval_r;

  logic [NW-1:0] dm_num_r [0:NW];
  logic [DW-1:0] dm_rem_r [0:NW];
  logic [NW-1:0] dd_num_r [0:NW];
  logic [DW-1:0] dd_rem_r [0:NW];
  logic [DW-1:0] dv_r     [0:NW];
  side_t         ds_r     [0:NW];
  logic [NW:0]   dval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gval_r[0] <= 1'b0;
      dval_r[0] <= 1'b0;
    end else if (en) begin
      gval_r[0] <= in_valid;
      dval_r[0] <= gval_r[GCD_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r[0]  <= '{u: in_mag, v: in_den, k: '0};
      gm_r[0] <= in_mag;
      gd_r[0] <= in_den;
      gs_r[0] <= in_side;
      dm_num_r[0] <= gm_r[GCD_STEPS] >> g_r[GCD_STEPS].k;
      dd_num_r[0] <= NW'(gd_r[GCD_STEPS] >> g_r[GCD_STEPS].k);
      dm_rem_r[0] <= '0;
      dd_rem_r[0] <= '0;
      dv_r[0]     <= g_r[GCD_STEPS].v;
      ds_r[0]     <= gs_r[GCD_STEPS];
    end
  end

  for (genvar s = 0; s < GCD_STEPS; s++) begin : g_gcd
    gst_t g_nxt;
    always_comb g_nxt = gcd_step(g_r[s]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        gval_r[s+1] <= 1'b0;
      end else if (en) begin
        gval_r[s+1] <= gval_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        g_r[s+1]  <= g_nxt;
        gm_r[s+1] <= gm_r[s];
        gd_r[s+1] <= gd_r[s];
        gs_r[s+1] <= gs_r[s];
      end
    end
  end

  for (genvar s = 0; s < NW; s++) begin : g_div
    logic [DW:0]   tm, td;
    logic          qm, qd;
    logic [DW-1:0] rm_nxt, rd_nxt;

    always_comb begin
      tm = {dm_rem_r[s], dm_num_r[s][NW-1]};
      td = {dd_rem_r[s], dd_num_r[s][NW-1]};
      qm = tm >= {1'b0, dv_r[s]};
      qd = td >= {1'b0, dv_r[s]};
      rm_nxt = qm ? DW'(tm - {1'b0, dv_r[s]}) : tm[DW-1:0];
      rd_nxt = qd ? DW'(td - {1'b0, dv_r[s]}) : td[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dval_r[s+1] <= 1'b0;
      end else if (en) begin
        dval_r[s+1] <= dval_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dm_rem_r[s+1] <= rm_nxt;
        dd_rem_r[s+1] <= rd_nxt;
        dm_num_r[s+1] <= {dm_num_r[s][NW-2:0], qm};
        dd_num_r[s+1] <= {dd_num_r[s][NW-2:0], qd};
        dv_r[s+1]     <= dv_r[s];
        ds_r[s+1]     <= ds_r[s];
      end
    end
  end

  assign out_valid = dval_r[NW];
  assign out_mag   = dm_num_r[NW];
  assign out_den   = dd_num_r[NW][DW-1:0];
  assign out_side  = ds_r[NW];

endmodule

// ----- sv/rational_arithmetic_unit.sv -----
// Channel    | dir | payload
// in_ch      | in  | req_type, left_num, left_den, right_num, right_den
// out_ch     | out | result_num, result_den, status
// One transaction accepted per cycle while out_ch is not stalled.
// Data passes the 125-step gcd chain and the two 63-step dividers in rau_reduce.
// A stall at out_ch freezes every stage; in_ch.ready drops with it.
// Synchronous active-low reset clears the valid bits only.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WIDTH = RAU_WIDTH
) (
  input logic     clk,
  input logic     rst_n,
  rau_req_if.sink   in_ch,
  rau_rsp_if.source out_ch
);

  localparam logic [NW-1:0] LIM    = NW'(1) << (WIDTH - 1);
  localparam logic [NW-1:0] LIM_M1 = LIM - 1'b1;

  logic adv;
  op_t  op;
  logic s1n, s2n;
  logic [MAG_W-1:0] m1, m2, d1e, d2e;
  logic [MAG_W-1:0] ax, ay, bx, by, dx, dy;
  logic sa, sb, err;

  logic             s1_valid_r, s2_valid_r, s3_valid_r;
  logic [MAG_W-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r, s1_dx_r, s1_dy_r;
  logic             s1_sa_r, s1_sb_r, s1_err_r;
  logic [2*MAG_W-1:0] prod_a, prod_b, prod_d;
  logic [NW-1:0]    s2_a_r, s2_b_r;
  logic [DW-1:0]    s2_den_r;
  logic             s2_sa_r, s2_sb_r, s2_err_r;
  logic [NW-1:0]    mag_nxt;
  logic             neg_nxt;
  logic [NW-1:0]    s3_mag_r;
  logic [DW-1:0]    s3_den_r;
  side_t            s3_side_r;

  logic             red_valid;
  logic [NW-1:0]    red_mag, neg_mag;
  logic [DW-1:0]    red_den;
  side_t            red_side;
  logic             ovf;

  logic             out_valid_r;
  logic [NUM_W-1:0] out_num_r, out_num_nxt;
  logic [DEN_W-1:0] out_den_r, out_den_nxt;
  status_t          out_status_r, out_status_nxt;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    op  = op_t'(in_ch.req_type);
    s1n = in_ch.left_num[NUM_W-1];
    s2n = in_ch.right_num[NUM_W-1];
    m1  = s1n ? (~in_ch.left_num + 1'b1) : in_ch.left_num;
    m2  = s2n ? (~in_ch.right_num + 1'b1) : in_ch.right_num;
    d1e = MAG_W'(in_ch.left_den);
    d2e = MAG_W'(in_ch.right_den);
    err = (d1e == '0) || (d2e == '0) || (op == OP_DIV && m2 == '0);
    ax = m1;  ay = d2e;
    bx = m2;  by = d1e;
    dx = d1e; dy = d2e;
    sa = s1n; sb = s2n;
    case (op)
      OP_ADD: begin
        sb = s2n;
      end
      OP_SUB: begin
        sb = !s2n;
      end
      OP_MUL: begin
        ay = m2;
        bx = '0;
        sa = s1n ^ s2n;
        sb = 1'b0;
      end
      OP_DIV: begin
        bx = '0;
        dy = m2;
        sa = s1n ^ s2n;
        sb = 1'b0;
      end
      default: begin
        sb = s2n;
      end
    endcase
  end

  assign prod_a = s1_ax_r * s1_ay_r;
  assign prod_b = s1_bx_r * s1_by_r;
  assign prod_d = s1_dx_r * s1_dy_r;

  always_comb begin
    if (s2_sa_r == s2_sb_r) begin
      mag_nxt = s2_a_r + s2_b_r;
      neg_nxt = s2_sa_r;
    end else if (s2_a_r >= s2_b_r) begin
      mag_nxt = s2_a_r - s2_b_r;
      neg_nxt = s2_sa_r;
    end else begin
      mag_nxt = s2_b_r - s2_a_r;
      neg_nxt = s2_sb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax_r  <= ax;
      s1_ay_r  <= ay;
      s1_bx_r  <= bx;
      s1_by_r  <= by;
      s1_dx_r  <= dx;
      s1_dy_r  <= dy;
      s1_sa_r  <= sa;
      s1_sb_r  <= sb;
      s1_err_r <= err;
      s2_a_r   <= prod_a[NW-1:0];
      s2_b_r   <= prod_b[NW-1:0];
      s2_den_r <= prod_d[DW-1:0];
      s2_sa_r  <= s1_sa_r;
      s2_sb_r  <= s1_sb_r;
      s2_err_r <= s1_err_r;
      s3_mag_r <= mag_nxt;
      s3_den_r <= s2_den_r;
      s3_side_r <= '{neg: neg_nxt && (mag_nxt != '0), err: s2_err_r,
                     zero: mag_nxt == '0};
    end
  end

  rau_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s3_valid_r),
    .in_mag    (s3_mag_r),
    .in_den    (s3_den_r),
    .in_side   (s3_side_r),
    .out_valid (red_valid),
    .out_mag   (red_mag),
    .out_den   (red_den),
    .out_side  (red_side)
  );

  always_comb begin
    neg_mag = ~red_mag + 1'b1;
    ovf = (NW'(red_den) > LIM_M1) ||
          (red_side.neg ? (red_mag > LIM) : (red_mag > LIM_M1));
    out_num_nxt    = '0;
    out_den_nxt    = DEN_W'(1);
    out_status_nxt = ST_OK;
    if (red_side.err) begin
      out_status_nxt = ST_ZERO;
    end else if (red_side.zero) begin
      out_status_nxt = ST_OK;
    end else if (ovf) begin
      out_status_nxt = ST_OVF;
    end else begin
      out_num_nxt = red_side.neg ? neg_mag[NUM_W-1:0] : red_mag[NUM_W-1:0];
      out_den_nxt = red_den[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= red_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_num_r    <= out_num_nxt;
      out_den_r    <= out_den_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.result_num = out_num_r;
  assign out_ch.result_den = out_den_r;
  assign out_ch.status     = out_status_r;

endmodule

// ----- sv/rau_checker.sv -----
// Port-level checker for rational_arithmetic_unit, bound to the top level.
// Depends on rau_pkg, rau_if and assert_macros.svh.
`include "assert_macros.svh"

module rau_checker import rau_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  rau_req_if.sink   in_ch,
  rau_rsp_if.source out_ch
);

  `RAU_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_ch.valid, "result valid after reset")
  `RAU_ASSERT(a_err_zero, out_ch.valid && out_ch.status != ST_OK |-> out_ch.result_num == 0 && out_ch.result_den == 1, "error result not 0/1")
  `RAU_ASSERT(a_den_pos, out_ch.valid && out_ch.status == ST_OK |-> out_ch.result_den != 0, "zero denominator in ok result")
  `RAU_ASSERT(a_ready_free, !out_ch.valid |-> in_ch.ready, "input stalled with empty output")
  `RAU_ASSERT(a_hold, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_num) && $stable(out_ch.result_den) && $stable(out_ch.status), "stalled result changed")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// ----- dv/rational_arithmetic_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for rational_arithmetic_unit: directed table then random
// fractions, each result compared with a table value or an internal fraction calculator.
// Depends on rau_pkg, rau_if and the RTL top level.
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 250;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CALM_TAIL = 200;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    status_t                 st;
  } fraction_t;

  typedef struct {
    op_t                     op;
    logic signed [NUM_W-1:0] ln;
    logic [DEN_W-1:0]        ld;
    logic signed [NUM_W-1:0] rn;
    logic [DEN_W-1:0]        rd;
    bit                      typed;
    fraction_t               want;
  } row_t;

  localparam logic signed [NUM_W-1:0] NMIN = 32'sh8000_0000;
  localparam logic signed [NUM_W-1:0] NMAX = 32'sh7fff_ffff;
  localparam logic [DEN_W-1:0] DMAX = 31'h7fff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rau_req_if req_ch ();
  rau_rsp_if rsp_ch ();

  rational_arithmetic_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch.sink),
    .out_ch(rsp_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  row_t dir_rows[] = '{
    '{OP_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1, 1'b1, '{32'sd0, 31'd1, ST_ZERO}},
    '{OP_MUL, 32'sd3, 31'd2, 32'sd1, 31'd0, 1'b1, '{32'sd0, 31'd1, ST_ZERO}},
    '{OP_DIV, 32'sd5, 31'd0, 32'sd0, 31'd0, 1'b1, '{32'sd0, 31'd1, ST_ZERO}},
    '{OP_DIV, 32'sd7, 31'd3, 32'sd0, 31'd9, 1'b1, '{32'sd0, 31'd1, ST_ZERO}},
    '{OP_ADD, 32'sd0, 31'd5, 32'sd0, 31'd7, 1'b1, '{32'sd0, 31'd1, ST_OK}},
    '{OP_SUB, 32'sd4, 31'd6, 32'sd2, 31'd3, 1'b1, '{32'sd0, 31'd1, ST_OK}},
    '{OP_MUL, NMIN, 31'd1, -32'sd1, 31'd1, 1'b1, '{32'sd0, 31'd1, ST_OVF}},
    '{OP_SUB, NMIN, 31'd1, 32'sd0, 31'd1, 1'b1, '{NMIN, 31'd1, ST_OK}},
    '{OP_ADD, NMAX, 31'd1, 32'sd1, 31'd1, 1'b1, '{32'sd0, 31'd1, ST_OVF}},
    '{OP_ADD, 32'sd1, DMAX, 32'sd1, DMAX - 31'd1, 1'b1, '{32'sd0, 31'd1, ST_OVF}},
    '{OP_DIV, NMAX, DMAX, NMAX, DMAX, 1'b1, '{32'sd1, 31'd1, ST_OK}},
    '{OP_MUL, 32'sd1, DMAX, 32'sd1, 31'd1, 1'b1, '{32'sd1, DMAX, ST_OK}},
    '{OP_MUL, 32'sd1, DMAX, 32'sd1, 31'd2, 1'b0, '{32'sd0, 31'd1, ST_OK}},
    '{OP_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3, 1'b0, '{32'sd0, 31'd1, ST_OK}},
    '{OP_SUB, 32'sd1, 31'd2, 32'sd1, 31'd3, 1'b0, '{32'sd0, 31'd1, ST_OK}},
    '{OP_SUB, -32'sd3, 31'd4, 32'sd5, 31'd6, 1'b0, '{32'sd0, 31'd1, ST_OK}},
    '{OP_MUL, -32'sd6, 31'd35, -32'sd14, 31'd9, 1'b0, '{32'sd0, 31'd1, ST_OK}},
    '{OP_DIV, 32'sd6, 31'd35, -32'sd14, 31'd9, 1'b0, '{32'sd0, 31'd1, ST_OK}},
    '{OP_DIV, NMIN, 31'd1, NMIN, 31'd1, 1'b0, '{32'sd0, 31'd1, ST_OK}},
    '{OP_ADD, NMIN, DMAX, NMIN, DMAX - 31'd1, 1'b0, '{32'sd0, 31'd1, ST_OK}},
    '{OP_SUB, NMAX, 31'd1, NMIN, 31'd1, 1'b0, '{32'sd0, 31'd1, ST_OK}},
    '{OP_DIV, -32'sd1, DMAX, NMIN, 31'd1, 1'b0, '{32'sd0, 31'd1, ST_OK}}
  };

  fraction_t pending_fractions[$];
  fraction_t staged_fraction;
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned received = 0;
  int unsigned ok_count = 0;
  int unsigned zero_count = 0;
  int unsigned ovf_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_burst = 0;

  function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic fraction_t rational_result(op_t op, logic signed [NUM_W-1:0] ln,
                                                logic [DEN_W-1:0] ld,
                                                logic signed [NUM_W-1:0] rn,
                                                logic [DEN_W-1:0] rd);
    longint sl, sr;
    longint unsigned m1, m2, d1, d2, lcm, a, b, mag, den, g, lim;
    bit s1, s2, neg;
    fraction_t r;
    r = '{32'sd0, 31'd1, ST_ZERO};
    sl = ln;
    sr = rn;
    s1 = ln[NUM_W-1];
    s2 = rn[NUM_W-1];
    m1 = s1 ? -sl : sl;
    m2 = s2 ? -sr : sr;
    d1 = ld;
    d2 = rd;
    if (d1 == 0 || d2 == 0) return r;
    case (op)
      OP_ADD, OP_SUB: begin
        lcm = (d1 / euclid_gcd(d1, d2)) * d2;
        a = m1 * (lcm / d1);
        b = m2 * (lcm / d2);
        if (op == OP_SUB) s2 = !s2;
        if (s1 == s2) begin
          mag = a + b;
          neg = s1;
        end else if (a >= b) begin
          mag = a - b;
          neg = s1;
        end else begin
          mag = b - a;
          neg = s2;
        end
        den = lcm;
      end
      OP_MUL: begin
        mag = m1 * m2;
        den = d1 * d2;
        neg = s1 != s2;
      end
      default: begin
        if (m2 == 0) return r;
        mag = m1 * d2;
        den = d1 * m2;
        neg = s1 != s2;
      end
    endcase
    if (mag == 0) begin
      den = 1;
      neg = 1'b0;
    end else begin
      g = euclid_gcd(mag, den);
      mag = mag / g;
      den = den / g;
    end
    lim = 64'd1 << (RAU_WIDTH - 1);
    if (den > lim - 1 || (neg ? mag > lim : mag > lim - 1)) begin
      r.st = ST_OVF;
      return r;
    end
    r.num = neg ? NUM_W'(-mag) : NUM_W'(mag);
    r.den = DEN_W'(den);
    r.st = ST_OK;
    return r;
  endfunction

  function automatic logic [31:0] pick_num(int unsigned style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(64) - 32;
      2: return $urandom_range(5000) - 2500;
      default: return $urandom_range(1) ? NMIN : NMAX - $urandom_range(3);
    endcase
  endfunction

  function automatic logic [30:0] pick_den(int unsigned style);
    if ($urandom_range(39) == 0) return '0;
    case (style)
      0: return $urandom_range(DMAX, 1);
      1: return $urandom_range(40, 1);
      2: return $urandom_range(6000, 1);
      default: return DMAX - $urandom_range(3);
    endcase
  endfunction

  task automatic send_fraction_pair(op_t op, logic signed [NUM_W-1:0] ln,
                                    logic [DEN_W-1:0] ld, logic signed [NUM_W-1:0] rn,
                                    logic [DEN_W-1:0] rd, fraction_t want);
    int unsigned gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(11, 1);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= op;
    req_ch.left_num <= ln;
    req_ch.left_den <= ld;
    req_ch.right_num <= rn;
    req_ch.right_den <= rd;
    staged_fraction <= want;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (recv_burst != 0) begin
      recv_burst <= recv_burst - 1;
      rsp_ch.ready <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
      recv_burst <= $urandom_range(10);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready) pending_fractions.push_back(staged_fraction);
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      received++;
      if (pending_fractions.size() == 0) begin
        $error("unexpected transaction: num %0d den %0d status %s", rsp_ch.result_num,
               rsp_ch.result_den, rsp_ch.status.name());
        errors++;
      end else begin
        fraction_t w;
        w = pending_fractions.pop_front();
        if (rsp_ch.result_num !== w.num) begin
          $error("result_num: expected %0d, actual %0d", w.num, rsp_ch.result_num);
          errors++;
        end
        if (rsp_ch.result_den !== w.den) begin
          $error("result_den: expected %0d, actual %0d", w.den, rsp_ch.result_den);
          errors++;
        end
        if (rsp_ch.status !== w.st) begin
          $error("status: expected %0d, actual %0d", w.st, rsp_ch.status);
          errors++;
        end
        case (w.st)
          ST_OK:   ok_count++;
          ST_ZERO: zero_count++;
          default: ovf_count++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fraction_t want;
    op_t op;
    logic signed [NUM_W-1:0] ln, rn;
    logic [DEN_W-1:0] ld, rd;
    int unsigned style;
    req_ch.valid = 1'b0;
    req_ch.req_type = OP_ADD;
    req_ch.left_num = '0;
    req_ch.left_den = '0;
    req_ch.right_num = '0;
    req_ch.right_den = '0;
    rsp_ch.ready = 1'b0;
    staged_fraction = '{32'sd0, 31'd1, ST_OK};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      want = dir_rows[i].typed ? dir_rows[i].want :
             rational_result(dir_rows[i].op, dir_rows[i].ln, dir_rows[i].ld,
                             dir_rows[i].rn, dir_rows[i].rd);
      send_fraction_pair(dir_rows[i].op, dir_rows[i].ln, dir_rows[i].ld,
                         dir_rows[i].rn, dir_rows[i].rd, want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        send_idle_pct = (n >= RANDOM_ITEMS - CALM_TAIL) ? 0 : $urandom_range(2) * 15;
        recv_idle_pct = (n >= RANDOM_ITEMS - CALM_TAIL) ? 0 : $urandom_range(2) * 15;
      end
      style = $urandom_range(3);
      op = op_t'($urandom_range(3));
      ln = pick_num(style);
      rn = ($urandom_range(15) == 0) ? '0 : pick_num($urandom_range(3));
      ld = pick_den(style);
      rd = pick_den($urandom_range(3));
      send_fraction_pair(op, ln, ld, rn, rd, rational_result(op, ln, ld, rn, rd));
    end
    req_ch.valid <= 1'b0;

    while (pending_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d fraction pairs, checked %0d results", sent, received);
    $display("status mix: %0d ok, %0d zero denominator, %0d overflow",
             ok_count, zero_count, ovf_count);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
